[hw/rtl/positional_insert_delete_array_defines.svh]
// Assertion macros for the positional insert/delete array.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PIDA_CLK_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PIDA_SAME_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PIDA_NEXT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pida_pkg.sv]
// Shared types and constants of the positional insert/delete array.
package pida_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic                load;
    logic [WORD_W-1:0]   value;
  } cell_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0]   read_value;
    logic [SIZE_W-1:0]   size;
    logic [STAT_W-1:0]   status;
  } result_t;

endpackage

[hw/rtl/pida_cell.sv]
// One storage cell of the shift chain: hold, take a neighbor, or load a value.
module pida_cell #(
  parameter int unsigned AW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                          clk,
  input  pida_pkg::cell_ctl_t           ctl,
  input  logic [AW-1:0]                 pos,
  input  logic [pida_pkg::WORD_W-1:0]   prev_d,
  input  logic [pida_pkg::WORD_W-1:0]   next_d,
  output logic [pida_pkg::WORD_W-1:0]   data_q
);
  import pida_pkg::*;

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              at_ge;
  logic              at_eq;

  assign at_ge = (MY_IDX >= pos);
  assign at_eq = (MY_IDX == pos);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_UP: begin
        if (at_eq && ctl.load) begin
          data_nxt = ctl.value;
        end else if (at_ge) begin
          data_nxt = prev_d;
        end
      end
      CELL_DOWN: begin
        if (at_ge) begin
          data_nxt = next_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[hw/rtl/positional_insert_delete_array.sv]
// Top level of the positional insert/delete array: control and cell chain.
//
// Usage: one request on the in_ stream carries an action (read, append, pop,
// remove at, insert at, erase range); each request gives exactly one result
// on the out_ stream with the read value, the new size and a status.
// Append, pop, remove, insert, erase of at most one entry and a read at
// index 0 finish in the accept cycle; the result is valid on the next cycle
// if the output register is free. A read at index k > 0 in range rotates the
// whole cell chain down k steps and back up k steps; an erase of n entries
// shifts the chain down once per entry. in_tready is high only when no
// multi-cycle action runs; single-step actions sustain one request per cycle
// while results drain. Results go to an output register; if it is occupied a
// finished result waits in a holding stage and in_tready drops until it moves
// on, so a stalled receiver holds off the input after at most two results.
// Reset (rst_n low, synchronous) clears the live count and out_tvalid;
// stored words stay undefined and need no clearing pass.
`include "positional_insert_delete_array_defines.svh"

module positional_insert_delete_array #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action[2:0], index[9:3], value[41:10], count[48:42], zero pad
  input  logic [pida_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_value[31:0], size[38:32], status[40:39], zero pad
  output logic [pida_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import pida_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FWD,
    ST_RD_BACK,
    ST_ERASE,
    ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [WORD_W-1:0]   rd_r, rd_nxt;
  result_t             hold_r, hold_nxt;
  result_t             out_res_r, out_res_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [ACT_W-1:0]    in_action;
  logic [IDX_W-1:0]    in_index;
  logic [WORD_W-1:0]   in_value;
  logic [CNT_W-1:0]    in_count;

  logic [CMPW-1:0]     idx_e, live_e, cnt_e, rem_e, n_e;
  logic                live_full;
  logic                out_free;
  logic                fin;
  result_t             fin_res;
  logic                pop_acc;

  cell_ctl_t           cell_ctl;
  logic [AW-1:0]       cell_pos;
  logic [WORD_W-1:0]   cell_q [DEPTH];

  assign in_action = in_tdata[2:0];
  assign in_index  = in_tdata[9:3];
  assign in_value  = in_tdata[41:10];
  assign in_count  = in_tdata[48:42];

  assign idx_e     = CMPW'(in_index);
  assign live_e    = CMPW'(live_r);
  assign cnt_e     = CMPW'(in_count);
  assign rem_e     = live_e - idx_e;
  assign n_e       = (cnt_e < rem_e) ? cnt_e : rem_e;
  assign live_full = (live_e >= CMPW'(DEPTH));
  assign out_free  = !out_valid_r || out_tready;
  assign pop_acc   = in_tvalid && in_tready && (in_action == ACT_POP) && (live_r != '0);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.status, out_res_r.size, out_res_r.read_value};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned PREV = (g == 0) ? DEPTH - 1 : g - 1;
    localparam int unsigned NEXT = (g == DEPTH - 1) ? 0 : g + 1;
    pida_cell #(
      .AW  (AW),
      .IDX (g)
    ) u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .pos    (cell_pos),
      .prev_d (cell_q[PREV]),
      .next_d (cell_q[NEXT]),
      .data_q (cell_q[g])
    );
  end

  always_comb begin
    state_nxt          = state_r;
    live_nxt           = live_r;
    cnt_nxt            = cnt_r;
    idx_nxt            = idx_r;
    rd_nxt             = rd_r;
    hold_nxt           = hold_r;
    out_res_nxt        = out_res_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    cell_ctl.op        = CELL_HOLD;
    cell_ctl.load      = 1'b0;
    cell_ctl.value     = in_value;
    cell_pos           = '0;
    fin                = 1'b0;
    fin_res.read_value = '0;
    fin_res.size       = '0;
    fin_res.status     = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          fin = 1'b1;
          case (in_action)
            ACT_READ: begin
              if (idx_e >= live_e) begin
                fin_res.status = STAT_RANGE;
              end else if (idx_e == '0) begin
                fin_res.read_value = cell_q[0];
              end else begin
                fin         = 1'b0;
                cell_ctl.op = CELL_DOWN;
                rd_nxt      = cell_q[1];
                idx_nxt     = AW'(idx_e);
                if (idx_e == CMPW'(1)) begin
                  state_nxt = ST_RD_BACK;
                  cnt_nxt   = CW'(idx_e);
                end else begin
                  state_nxt = ST_RD_FWD;
                  cnt_nxt   = CW'(idx_e) - CW'(1);
                end
              end
            end
            ACT_APPEND: begin
              if (live_full) begin
                fin_res.status = STAT_FULL;
              end else begin
                cell_ctl.op   = CELL_UP;
                cell_ctl.load = 1'b1;
                cell_pos      = AW'(live_r);
                live_nxt      = live_r + CW'(1);
              end
            end
            ACT_POP: begin
              if (live_r == '0) begin
                fin_res.status = STAT_EMPTY;
              end else begin
                live_nxt = live_r - CW'(1);
              end
            end
            ACT_REMOVE: begin
              if (idx_e >= live_e) begin
                fin_res.status = STAT_RANGE;
              end else begin
                cell_ctl.op = CELL_DOWN;
                cell_pos    = AW'(idx_e);
                live_nxt    = live_r - CW'(1);
              end
            end
            ACT_INSERT: begin
              if (idx_e > live_e) begin
                fin_res.status = STAT_RANGE;
              end else if (live_full) begin
                fin_res.status = STAT_FULL;
              end else begin
                cell_ctl.op   = CELL_UP;
                cell_ctl.load = 1'b1;
                cell_pos      = AW'(idx_e);
                live_nxt      = live_r + CW'(1);
              end
            end
            ACT_ERASE: begin
              if (idx_e >= live_e) begin
                fin_res.status = STAT_RANGE;
              end else if (n_e != '0) begin
                cell_ctl.op = CELL_DOWN;
                cell_pos    = AW'(idx_e);
                live_nxt    = live_r - CW'(1);
                if (n_e != CMPW'(1)) begin
                  fin       = 1'b0;
                  state_nxt = ST_ERASE;
                  idx_nxt   = AW'(idx_e);
                  cnt_nxt   = CW'(n_e) - CW'(1);
                end
              end
            end
            default: fin_res.status = STAT_OK;
          endcase
        end
      end
      ST_RD_FWD: begin
        cell_ctl.op = CELL_DOWN;
        rd_nxt      = cell_q[1];
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_RD_BACK;
          cnt_nxt   = CW'(idx_r);
        end
      end
      ST_RD_BACK: begin
        cell_ctl.op = CELL_UP;
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          fin                = 1'b1;
          fin_res.read_value = rd_r;
        end
      end
      ST_ERASE: begin
        cell_ctl.op = CELL_DOWN;
        cell_pos    = idx_r;
        live_nxt    = live_r - CW'(1);
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          fin = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = hold_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    fin_res.size = SIZE_W'(live_nxt);

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = fin_res;
        state_nxt     = ST_IDLE;
      end else begin
        hold_nxt  = fin_res;
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    rd_r      <= rd_nxt;
    hold_r    <= hold_nxt;
    out_res_r <= out_res_nxt;
  end

  `PIDA_CLK_ASSERT(a_live_bound, live_r <= CW'(DEPTH), "live count above capacity")
  `PIDA_SAME_ASSERT(a_done_waits, state_r == ST_DONE, out_valid_r, "holding with free output")
  `PIDA_NEXT_ASSERT(a_pop_shrinks, pop_acc, live_r == $past(live_r) - CW'(1), "pop did not shrink")

endmodule

[tb/tb.sv]
// Self-checking testbench for the positional insert/delete array stream block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pida_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned IDLE_PCT   = 29;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned N_ITEMS    = 1850;

  localparam logic [ACT_W-1:0] ACT_NOP6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NOP7 = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] val;
    logic [IDX_W-1:0]  idx;
    logic [ACT_W-1:0]  act;
  } list_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  positional_insert_delete_array #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  list_req_t   pending_reqs[$];
  result_t     expected_results[$];

  // shadow list contents, updated on every accepted request
  logic [WORD_W-1:0] list_words[DEPTH];
  int unsigned       list_len;

  int unsigned gen_len;
  int unsigned n_gen;
  int unsigned n_req;
  int unsigned n_res;
  int unsigned n_errors;
  int unsigned peak_len;
  int unsigned stat_seen[4];
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          hold_done;
  bit          in_taken;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t apply_request(list_req_t r);
    result_t     res;
    int unsigned n;
    res.read_value = '0;
    res.status     = STAT_OK;
    case (r.act)
      ACT_READ: begin
        if (r.idx < list_len) res.read_value = list_words[r.idx];
        else res.status = STAT_RANGE;
      end
      ACT_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          list_words[list_len] = r.val;
          list_len++;
        end
      end
      ACT_POP: begin
        if (list_len == 0) res.status = STAT_EMPTY;
        else list_len--;
      end
      ACT_REMOVE: begin
        if (r.idx >= list_len) begin
          res.status = STAT_RANGE;
        end else begin
          for (int unsigned i = r.idx; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      ACT_INSERT: begin
        if (r.idx > list_len) begin
          res.status = STAT_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (int unsigned i = list_len; i > r.idx; i--) list_words[i] = list_words[i - 1];
          list_words[r.idx] = r.val;
          list_len++;
        end
      end
      ACT_ERASE: begin
        if (r.idx >= list_len) begin
          res.status = STAT_RANGE;
        end else begin
          n = list_len - r.idx;
          if (r.cnt < n) n = r.cnt;
          for (int unsigned i = r.idx; i + n < list_len; i++) list_words[i] = list_words[i + n];
          list_len -= n;
        end
      end
      default: ;
    endcase
    res.size = list_len[SIZE_W-1:0];
    return res;
  endfunction

  // generator-side length tracking, so indices land mostly inside the list
  task automatic queue_req(logic [ACT_W-1:0] act, int unsigned idx, logic [WORD_W-1:0] val,
                           int unsigned cnt);
    list_req_t r;
    int unsigned n;
    r.act = act;
    r.idx = idx[IDX_W-1:0];
    r.val = val;
    r.cnt = cnt[CNT_W-1:0];
    pending_reqs.insert(pending_reqs.size(), r);
    if (act != ACT_NOP6 && act != ACT_NOP7) n_gen++;
    case (act)
      ACT_APPEND: if (gen_len < DEPTH) gen_len++;
      ACT_POP:    if (gen_len > 0) gen_len--;
      ACT_REMOVE: if (idx < gen_len) gen_len--;
      ACT_INSERT: if (idx <= gen_len && gen_len < DEPTH) gen_len++;
      ACT_ERASE: begin
        if (idx < gen_len) begin
          n = gen_len - idx;
          if (cnt < n) n = cnt;
          gen_len -= n;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_index(bit for_insert);
    if ($urandom_range(99) < 85) begin
      if (for_insert) return $urandom_range(gen_len, 0);
      if (gen_len > 0) return $urandom_range(gen_len - 1, 0);
    end
    return $urandom_range(DEPTH);
  endfunction

  function automatic int unsigned pick_count();
    if ($urandom_range(3) == 0) return $urandom_range(DEPTH);
    return $urandom_range(4);
  endfunction

  task automatic queue_random(logic [ACT_W-1:0] act);
    queue_req(act, pick_index(act == ACT_INSERT), rand_word(), pick_count());
  endtask

  task automatic build_stimulus();
    int unsigned pct;
    // empty-list corner cases
    queue_req(ACT_READ,   0, 32'h1234_5678, 0);
    queue_req(ACT_POP,    0, 0, 0);
    queue_req(ACT_REMOVE, 0, 0, 0);
    queue_req(ACT_ERASE,  0, 0, 1);
    queue_req(ACT_INSERT, 1, 32'h5555_aaaa, 0);
    // build a four-entry list through every insert path
    queue_req(ACT_INSERT, 0, 32'h7fff_ffff, 0);
    queue_req(ACT_APPEND, 0, 32'h8000_0000, 0);
    queue_req(ACT_INSERT, 2, 32'hffff_ffff, 0);
    queue_req(ACT_INSERT, 1, 32'h0000_0000, 0);
    queue_req(ACT_READ,   0, 0, 0);
    queue_req(ACT_READ,   3, 0, 0);
    queue_req(ACT_READ,   4, 0, 0);
    queue_req(ACT_READ,   64, 32'hffff_ffff, 64);
    queue_req(ACT_NOP6,   127, 32'hffff_ffff, 127);
    queue_req(ACT_NOP7,   0, 0, 0);
    queue_req(ACT_ERASE,  1, 0, 0);
    queue_req(ACT_ERASE,  2, 0, 64);
    queue_req(ACT_REMOVE, 1, 0, 0);
    queue_req(ACT_REMOVE, 1, 0, 0);
    queue_req(ACT_POP,    0, 0, 0);
    queue_req(ACT_INSERT, 64, 32'h0f0f_0f0f, 0);
    queue_req(ACT_ERASE,  64, 0, 64);

    while (n_gen < N_ITEMS) begin
      case ($urandom_range(2))
        0: begin
          // fill to capacity, then knock on the full list
          while (gen_len < DEPTH) begin
            pct = $urandom_range(99);
            if (pct < 60)      queue_random(ACT_APPEND);
            else if (pct < 90) queue_random(ACT_INSERT);
            else               queue_random(ACT_READ);
          end
          queue_req(ACT_APPEND, 0, rand_word(), 0);
          queue_req(ACT_INSERT, $urandom_range(DEPTH - 1), rand_word(), 0);
          queue_req(ACT_INSERT, DEPTH, rand_word(), 0);
          queue_req(ACT_READ, DEPTH - 1, 0, 0);
        end
        1: begin
          // drain to empty, then poke the empty list
          while (gen_len > 0) begin
            pct = $urandom_range(99);
            if (pct < 30)      queue_random(ACT_POP);
            else if (pct < 60) queue_random(ACT_REMOVE);
            else if (pct < 85) queue_random(ACT_ERASE);
            else               queue_random(ACT_READ);
          end
          queue_req(ACT_POP, 0, 0, 0);
          queue_req(ACT_REMOVE, 0, 0, 0);
          queue_req(ACT_ERASE, 0, 0, pick_count());
          queue_req(ACT_READ, 0, 0, 0);
        end
        default: begin
          repeat (40) queue_random(3'($urandom_range(7)));
        end
      endcase
    end
  endtask

  // request side
  always @(negedge clk) begin : drive_requests
    list_req_t r;
    bit        quiet;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!(in_tvalid && !in_taken)) begin
      quiet = (n_req >= 1000 && n_req < 1300);
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_DATA_W - $bits(list_req_t)){1'b0}}, r};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side, with one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && n_req >= 700) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (n_req >= 1000 && n_req < 1300) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    list_req_t r;
    result_t   got;
    result_t   want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        n_res++;
        got.read_value = out_tdata[31:0];
        got.size       = out_tdata[38:32];
        got.status     = out_tdata[40:39];
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_value %0h size %0d status %0d",
                 got.read_value, got.size, got.status);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
            n_errors++;
          end
          if (got.size !== want.size) begin
            $error("size: expected %0d, got %0d", want.size, got.size);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_req++;
        r    = list_req_t'(in_tdata[$bits(list_req_t)-1:0]);
        want = apply_request(r);
        expected_results.insert(expected_results.size(), want);
        stat_seen[want.status]++;
        if (list_len > peak_len) peak_len = list_len;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a handshake", STALL_LIMIT);
      $display("positional_insert_delete_array: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    list_len = 0;
    gen_len  = 0;
    n_gen    = 0;
    n_req    = 0;
    n_res    = 0;
    n_errors = 0;
    peak_len = 0;
    foreach (stat_seen[i]) stat_seen[i] = 0;
    build_stimulus();
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_errors++;
    end

    $display("%0d requests, %0d results, peak list length %0d", n_req, n_res, peak_len);
    $display("status ok %0d, out of range %0d, empty %0d, full %0d",
             stat_seen[STAT_OK], stat_seen[STAT_RANGE], stat_seen[STAT_EMPTY],
             stat_seen[STAT_FULL]);
    if (n_errors == 0) begin
      $display("positional_insert_delete_array: match");
    end else begin
      $display("positional_insert_delete_array: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pida_pkg.sv
hw/rtl/pida_cell.sv
hw/rtl/positional_insert_delete_array.sv
tb/tb.sv
